### design/assert_macros.svh
// Assertion macros shared by the bar meter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is high.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### design/bmph_pkg.sv
// Types, register codes and channel tables for the bar meter.
package bmph_pkg;

  localparam int NUM_CHANNELS_DEF    = 6;
  localparam int RATIO_FRAC_BITS_DEF = 16;
  localparam int KINDS               = 6;
  localparam int LEVEL_W             = 17;
  localparam int STEP_W              = 17;
  localparam int CFG_INDEX_W         = 3;
  localparam int CFG_DATA_W          = 17;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_QRP_MODE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_FULL      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_QRP_FULL        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_STEP      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_DECAY_STEP = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_HOLD_TICKS = 3'd5;

  localparam logic [2:0] CH_POWER   = 3'd0;
  localparam logic [2:0] CH_ALC     = 3'd1;
  localparam logic [2:0] CH_COMP    = 3'd2;
  localparam logic [2:0] CH_SWR     = 3'd3;
  localparam logic [2:0] CH_CURRENT = 3'd4;
  localparam logic [2:0] CH_SMETER  = 3'd5;

  typedef struct packed {
    logic              qrp_mode;
    logic [7:0]        power_full_scale;
    logic [7:0]        qrp_full_scale;
    logic [STEP_W-1:0] decay_step;
    logic [STEP_W-1:0] peak_decay_step;
    logic [7:0]        peak_hold_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic        operation;
    logic [2:0]  channel;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] peak_mark;
    logic               changed;
    logic               last;
  } result_t;

  // The shared subtractor must hold a level and a 17-bit step.
  function automatic int unit_width(input int rfb);
    return (rfb + 1 > STEP_W) ? rfb + 1 : STEP_W;
  endfunction

  // Offset of each channel in whole units.
  function automatic logic [7:0] chan_offset(input logic [2:0] kind);
    case (kind)
      CH_SWR:  return 8'd1;
      default: return 8'd0;
    endcase
  endfunction

  // Full scale of each channel in whole units; power follows the registers.
  function automatic logic [7:0] chan_scale(input logic [2:0] kind, input cfg_regs_t cfg);
    logic [7:0] fs;
    fs = cfg.qrp_mode ? cfg.qrp_full_scale : cfg.power_full_scale;
    case (kind)
      CH_POWER:   return (fs == 8'd0) ? 8'd1 : fs;
      CH_ALC:     return 8'd7;
      CH_COMP:    return 8'd25;
      CH_SWR:     return 8'd2;
      CH_CURRENT: return 8'd25;
      CH_SMETER:  return 8'd15;
      default:    return 8'd1;
    endcase
  endfunction

endpackage

### design/bmph_sub.sv
// Shared subtract and compare unit used by every sequencer step.
module bmph_sub #(
  parameter int W = 17
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

### design/bmph_cfg.sv
// Configuration register file of the bar meter.
module bmph_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bmph_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bmph_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bmph_pkg::cfg_regs_t                regs
);
  import bmph_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.qrp_mode         <= 1'b0;
      regs.power_full_scale <= 8'd110;
      regs.qrp_full_scale   <= 8'd10;
      regs.decay_step       <= 17'd3277;
      regs.peak_decay_step  <= 17'd1311;
      regs.peak_hold_ticks  <= 8'd20;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_QRP_MODE:        regs.qrp_mode         <= cfg_data[0];
        REG_POWER_FULL:      regs.power_full_scale <= cfg_data[7:0];
        REG_QRP_FULL:        regs.qrp_full_scale   <= cfg_data[7:0];
        REG_DECAY_STEP:      regs.decay_step       <= cfg_data[STEP_W-1:0];
        REG_PEAK_DECAY_STEP: regs.peak_decay_step  <= cfg_data[STEP_W-1:0];
        REG_PEAK_HOLD_TICKS: regs.peak_hold_ticks  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### design/bmph_seq.sv
// Sequencer and per-channel level state of the bar meter.
`include "assert_macros.svh"
module bmph_seq #(
  parameter int NUM_CHANNELS    = bmph_pkg::NUM_CHANNELS_DEF,
  parameter int RATIO_FRAC_BITS = bmph_pkg::RATIO_FRAC_BITS_DEF,
  parameter int UW              = bmph_pkg::unit_width(RATIO_FRAC_BITS)
) (
  input  logic                clk,
  input  logic                rst,
  input  bmph_pkg::cfg_regs_t cfg,
  input  logic                item_valid,
  output logic                item_ready,
  input  bmph_pkg::item_t     item,
  input  logic                out_free,
  output logic                emit,
  output bmph_pkg::result_t   res,
  output logic [UW-1:0]       sub_a,
  output logic [UW-1:0]       sub_b,
  input  logic [UW-1:0]       sub_diff,
  input  logic                sub_borrow
);
  import bmph_pkg::*;

  localparam int RFB    = RATIO_FRAC_BITS;
  localparam int LW     = RFB + 1;
  localparam int ACTIVE = (NUM_CHANNELS < KINDS) ? NUM_CHANNELS : KINDS;
  localparam int CW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam int BCW    = $clog2(RFB);
  localparam logic [CW-1:0]  LAST_CH  = CW'(ACTIVE - 1);
  localparam logic [BCW-1:0] LAST_BIT = BCW'(RFB - 1);
  localparam logic [LW-1:0]  ONE      = {1'b1, {RFB{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_OFF, ST_SAT, ST_DIV, ST_CMP_D, ST_CMP_P,
    ST_DEC_D1, ST_DEC_D2, ST_DEC_D3, ST_DEC_P1, ST_DEC_P2, ST_DEC_P3, ST_EMIT
  } state_t;

  state_t          state;
  logic            is_tick;
  logic [CW-1:0]   chan;
  logic [15:0]     raw;
  logic [15:0]     raw_off;
  logic [15:0]     divisor;
  logic [15:0]     rem;
  logic [RFB-1:0]  quot;
  logic [BCW-1:0]  bit_cnt;
  logic [LW-1:0]   ratio;
  logic [UW-1:0]   gap;
  logic [LW-1:0]   d0;
  logic [LW-1:0]   p0;
  logic [LW-1:0]   target  [ACTIVE];
  logic [LW-1:0]   display [ACTIVE];
  logic [LW-1:0]   peak    [ACTIVE];
  logic [7:0]      hold    [ACTIVE];

  logic            gt;
  logic [RFB-1:0]  quot_next;

  assign gt         = !sub_borrow && (sub_diff != '0);
  assign quot_next  = {quot[RFB-2:0], ~sub_borrow};
  assign item_ready = (state == ST_IDLE);
  assign emit       = (state == ST_EMIT) && out_free;

  always_comb begin
    res.out_channel = 3'(chan);
    res.level       = LEVEL_W'(display[chan]);
    res.peak_mark   = LEVEL_W'(peak[chan]);
    res.changed     = (display[chan] != d0) || (peak[chan] != p0);
    res.last        = is_tick ? (chan == LAST_CH) : 1'b1;
  end

  // Operand selection for the shared subtractor.
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state)
      ST_OFF: begin
        sub_a = UW'(raw);
        sub_b = UW'(raw_off);
      end
      ST_SAT: begin
        sub_a = UW'(rem);
        sub_b = UW'(divisor);
      end
      ST_DIV: begin
        sub_a = UW'({rem, 1'b0});
        sub_b = UW'(divisor);
      end
      ST_CMP_D: begin
        sub_a = UW'(display[chan]);
        sub_b = UW'(ratio);
      end
      ST_CMP_P: begin
        sub_a = UW'(peak[chan]);
        sub_b = UW'(ratio);
      end
      ST_DEC_D1: begin
        sub_a = UW'(display[chan]);
        sub_b = UW'(target[chan]);
      end
      ST_DEC_D2: begin
        sub_a = gap;
        sub_b = UW'(cfg.decay_step);
      end
      ST_DEC_D3: begin
        sub_a = UW'(display[chan]);
        sub_b = UW'(cfg.decay_step);
      end
      ST_DEC_P1: begin
        sub_a = UW'(peak[chan]);
        sub_b = UW'(display[chan]);
      end
      ST_DEC_P2: begin
        sub_a = gap;
        sub_b = UW'(cfg.peak_decay_step);
      end
      ST_DEC_P3: begin
        sub_a = UW'(peak[chan]);
        sub_b = UW'(cfg.peak_decay_step);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      is_tick <= 1'b0;
      chan    <= '0;
      for (int k = 0; k < ACTIVE; k++) begin
        target[k]  <= '0;
        display[k] <= '0;
        peak[k]    <= '0;
        hold[k]    <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            if (item.operation == OP_TICK) begin
              is_tick <= 1'b1;
              chan    <= '0;
              state   <= ST_DEC_D1;
            end else if (item.channel < 3'(ACTIVE)) begin
              is_tick <= 1'b0;
              chan    <= item.channel[CW-1:0];
              raw     <= item.value;
              raw_off <= {chan_offset(item.channel), 8'h00};
              divisor <= {chan_scale(item.channel, cfg), 8'h00};
              state   <= ST_OFF;
            end
          end
        end
        ST_OFF: begin
          d0 <= display[chan];
          p0 <= peak[chan];
          if (gt) begin
            rem   <= 16'(sub_diff);
            state <= ST_SAT;
          end else begin
            ratio <= '0;
            state <= ST_CMP_D;
          end
        end
        ST_SAT: begin
          // A reading at or above full scale saturates without dividing.
          if (!sub_borrow) begin
            ratio <= ONE;
            state <= ST_CMP_D;
          end else begin
            bit_cnt <= '0;
            quot    <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem     <= sub_borrow ? {rem[14:0], 1'b0} : 16'(sub_diff);
          quot    <= quot_next;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == LAST_BIT) begin
            ratio <= LW'(quot_next);
            state <= ST_CMP_D;
          end
        end
        ST_CMP_D: begin
          target[chan] <= ratio;
          if (sub_borrow) begin
            display[chan] <= ratio;
          end
          state <= ST_CMP_P;
        end
        ST_CMP_P: begin
          if (sub_borrow) begin
            peak[chan] <= ratio;
            hold[chan] <= cfg.peak_hold_ticks;
          end
          state <= ST_EMIT;
        end
        ST_DEC_D1: begin
          d0 <= display[chan];
          p0 <= peak[chan];
          if (gt) begin
            gap   <= sub_diff;
            state <= ST_DEC_D2;
          end else begin
            state <= ST_DEC_P1;
          end
        end
        ST_DEC_D2: begin
          if (gt) begin
            state <= ST_DEC_D3;
          end else begin
            display[chan] <= target[chan];
            state         <= ST_DEC_P1;
          end
        end
        ST_DEC_D3: begin
          display[chan] <= LW'(sub_diff);
          state         <= ST_DEC_P1;
        end
        ST_DEC_P1: begin
          if (gt) begin
            if (hold[chan] != 8'd0) begin
              hold[chan] <= hold[chan] - 8'd1;
              state      <= ST_EMIT;
            end else begin
              gap   <= sub_diff;
              state <= ST_DEC_P2;
            end
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_DEC_P2: begin
          if (gt) begin
            state <= ST_DEC_P3;
          end else begin
            peak[chan] <= display[chan];
            state      <= ST_EMIT;
          end
        end
        ST_DEC_P3: begin
          peak[chan] <= LW'(sub_diff);
          state      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (res.last) begin
              state <= ST_IDLE;
            end else begin
              chan  <= chan + 1'b1;
              state <= ST_DEC_D1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_PROP(a_emit_free, clk, rst, emit |-> out_free, "result emitted into a full register")
  `ASSERT_PROP(a_peak_ge_level, clk, rst, emit |-> peak[chan] >= display[chan], "peak below level")
  `ASSERT_PROP(a_last_idle, clk, rst, emit && res.last |=> state == ST_IDLE, "no idle after last")
  `ASSERT_PROP(a_tick_start, clk, rst, item_valid && item_ready && item.operation == OP_TICK |=> state == ST_DEC_D1 && chan == '0, "tick did not start at channel zero")

endmodule

### design/bar_meter_peak_hold.sv
// Top level of the six-channel bar meter with peak hold and decay.
//
// A sample word scales one channel's Q8.8 reading to a fill ratio with
// RATIO_FRAC_BITS fraction bits, saturated to 0..1.0, raises the display
// and peak marker to it and reports that channel in one result word; a
// sample for a channel that does not exist is dropped without a result.
// A tick word decays every display toward its target, then holds or
// decays every peak toward its display, and reports all channels in
// ascending order with last set on the final word. Every step runs on one
// shared subtract and compare unit, so the block takes one word at a time.
// A sample compares the reading with its offset and, when above it, with
// full scale; below full scale it runs the restoring divider, one quotient
// bit per cycle, before it compares the ratio with the display and the
// peak and emits the result. A tick runs, for each channel, a display
// compare, a step compare and subtract, then the same for the peak, then
// the result. Results leave through an output register, so a stalled
// consumer only holds the sequencer when a new result is ready.
// Configuration writes are accepted in every cycle and must be made while
// the block is idle.
module bar_meter_peak_hold #(
  parameter int NUM_CHANNELS    = bmph_pkg::NUM_CHANNELS_DEF,
  parameter int RATIO_FRAC_BITS = bmph_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmph_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bmph_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  bmph_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output bmph_pkg::result_t                result
);
  import bmph_pkg::*;

  // Width of the shared unit: wide enough for a level and for a step.
  localparam int UW = unit_width(RATIO_FRAC_BITS);

  cfg_regs_t     regs;
  result_t       res;
  logic          emit;
  logic          out_free;
  logic [UW-1:0] sub_a;
  logic [UW-1:0] sub_b;
  logic [UW-1:0] sub_diff;
  logic          sub_borrow;

  bmph_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  bmph_sub #(
    .W (UW)
  ) u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  bmph_seq #(
    .NUM_CHANNELS    (NUM_CHANNELS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
    .UW              (UW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_free   (out_free),
    .emit       (emit),
    .res        (res),
    .sub_a      (sub_a),
    .sub_b      (sub_b),
    .sub_diff   (sub_diff),
    .sub_borrow (sub_borrow)
  );

  // The output register can take a new word when it is empty or is being
  // drained in this same cycle.
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // The payload needs no reset; it is only looked at while valid is high.
  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res;
    end
  end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the six-channel bar meter with peak hold and decay.
module testbench;
  import bmph_pkg::*;

  // The watchdog gives up after this many cycles in which no word moves on any channel.
  localparam int LIMIT_CYCLES    = 2000;
  // Drain wait: enough for a tick to walk all six channels, plus the output register.
  localparam int DRAIN_CYCLES    = 64;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 44;
  localparam int CHANNELS        = NUM_CHANNELS_DEF;

  localparam logic [LEVEL_W-1:0]     FULL_FILL   = 17'h10000;
  localparam logic [2:0]             CH_SPARE_LO = 3'd6;
  localparam logic [2:0]             CH_SPARE_HI = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE   = 3'd7;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   item_valid   = 1'b0;
  logic                   item_ready;
  item_t                  item         = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;

  bar_meter_peak_hold dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Our own copy of the meter: per-channel levels and the register file.
  logic [LEVEL_W-1:0] tgt_lvl  [CHANNELS] = '{default: '0};
  logic [LEVEL_W-1:0] disp_lvl [CHANNELS] = '{default: '0};
  logic [LEVEL_W-1:0] pk_lvl   [CHANNELS] = '{default: '0};
  logic [7:0]         hold_cnt [CHANNELS] = '{default: '0};

  logic               qrp_sel      = 1'b0;
  logic [7:0]         fs_normal    = 8'd110;
  logic [7:0]         fs_qrp       = 8'd10;
  logic [STEP_W-1:0]  fall_step    = 17'd3277;
  logic [STEP_W-1:0]  pk_fall_step = 17'd1311;
  logic [7:0]         hold_reload  = 8'd20;

  // Bar words still owed by the block, oldest first.
  result_t bars_due[$];
  bit      fault_seen   = 1'b0;
  int      quiet_cycles = 0;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // One row of the directed table: either a register write or a word to send.
  typedef struct {
    bit                     is_reg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    item_t                  word;
    bit                     typed;
    result_t                want;
  } stim_row_t;

  initial begin
    forever #2 clk = ~clk;
  end

  // Full scale of a channel in whole units; power follows the registers.
  function automatic logic [7:0] span_units(input logic [2:0] ch);
    logic [7:0] span;
    case (ch)
      CH_POWER:   span = qrp_sel ? fs_qrp : fs_normal;
      CH_ALC:     span = 8'd7;
      CH_COMP:    span = 8'd25;
      CH_SWR:     span = 8'd2;
      CH_CURRENT: span = 8'd25;
      default:    span = 8'd15;
    endcase
    // An empty power full scale reads as one watt.
    return (span == 8'd0) ? 8'd1 : span;
  endfunction

  // Q8.8 reading to a Q1.16 fill ratio, clipped at empty and at full.
  function automatic logic [LEVEL_W-1:0] fill_ratio(input logic [2:0] ch, input logic [15:0] raw);
    logic [15:0] base;
    logic [31:0] quot;
    base = (ch == CH_SWR) ? 16'h0100 : 16'h0000;
    if (raw <= base) return '0;
    quot = {raw - base, 16'h0000} / {span_units(ch), 8'h00};
    return (quot > 32'(FULL_FILL)) ? FULL_FILL : quot[LEVEL_W-1:0];
  endfunction

  // A step bigger than the remaining gap lands on the goal.
  function automatic logic [LEVEL_W-1:0] fall_toward(input logic [LEVEL_W-1:0] cur,
                                                     input logic [LEVEL_W-1:0] goal,
                                                     input logic [STEP_W-1:0]  step);
    return (cur - goal > step) ? cur - step : goal;
  endfunction

  // Advances the meter by one accepted word and queues the bar words it owes.
  function automatic void advance_meter(input item_t w);
    int                 ch;
    logic [LEVEL_W-1:0] ratio;
    logic [LEVEL_W-1:0] d0;
    logic [LEVEL_W-1:0] p0;
    result_t            bar;
    ch = int'(w.channel);
    if (w.operation == OP_SAMPLE) begin
      if (ch >= CHANNELS) return;
      ratio       = fill_ratio(w.channel, w.value);
      tgt_lvl[ch] = ratio;
      bar.changed = 1'b0;
      if (ratio > disp_lvl[ch]) begin
        disp_lvl[ch] = ratio;
        bar.changed  = 1'b1;
      end
      if (ratio > pk_lvl[ch]) begin
        pk_lvl[ch]   = ratio;
        hold_cnt[ch] = hold_reload;
        bar.changed  = 1'b1;
      end
      bar.out_channel = w.channel;
      bar.level       = disp_lvl[ch];
      bar.peak_mark   = pk_lvl[ch];
      bar.last        = 1'b1;
      bars_due.push_back(bar);
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        d0 = disp_lvl[i];
        p0 = pk_lvl[i];
        if (disp_lvl[i] > tgt_lvl[i]) disp_lvl[i] = fall_toward(disp_lvl[i], tgt_lvl[i], fall_step);
        // The peak first waits out its hold, then chases the display down.
        if (pk_lvl[i] > disp_lvl[i]) begin
          if (hold_cnt[i] != 8'd0) hold_cnt[i] = hold_cnt[i] - 8'd1;
          else pk_lvl[i] = fall_toward(pk_lvl[i], disp_lvl[i], pk_fall_step);
        end
        bar.out_channel = 3'(i);
        bar.level       = disp_lvl[i];
        bar.peak_mark   = pk_lvl[i];
        bar.changed     = (d0 != disp_lvl[i]) || (p0 != pk_lvl[i]);
        bar.last        = (i == CHANNELS - 1);
        bars_due.push_back(bar);
      end
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0]  val);
    case (idx)
      REG_QRP_MODE:        qrp_sel      = val[0];
      REG_POWER_FULL:      fs_normal    = val[7:0];
      REG_QRP_FULL:        fs_qrp       = val[7:0];
      REG_DECAY_STEP:      fall_step    = val[STEP_W-1:0];
      REG_PEAK_DECAY_STEP: pk_fall_step = val[STEP_W-1:0];
      REG_PEAK_HOLD_TICKS: hold_reload  = val[7:0];
      default: ;
    endcase
  endfunction

  // Receiver: ready is redrawn every cycle according to the stall rate of the phase.
  always @(posedge clk) begin
    result_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Everything is sampled at the falling edge, where it is stable and shows
  // exactly what the next rising edge will accept.
  always @(negedge clk) begin
    result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (bars_due.size() == 0) begin
          $display("%0t: unexpected bar word: ch %0d level %0d peak %0d changed %0b last %0b",
                   $time, result.out_channel, result.level, result.peak_mark,
                   result.changed, result.last);
          fault_seen = 1'b1;
        end else begin
          want = bars_due.pop_front();
          if (result.out_channel !== want.out_channel || result.level !== want.level ||
              result.peak_mark !== want.peak_mark || result.changed !== want.changed ||
              result.last !== want.last) begin
            $display("%0t: bar word mismatch: expected ch %0d level %0d peak %0d changed %0b last %0b",
                     $time, want.out_channel, want.level, want.peak_mark, want.changed, want.last);
            $display("%0t:                    actual   ch %0d level %0d peak %0d changed %0b last %0b",
                     $time, result.out_channel, result.level, result.peak_mark,
                     result.changed, result.last);
            fault_seen = 1'b1;
          end
        end
      end
      if ((item_valid && item_ready) || (result_valid && result_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= LIMIT_CYCLES) begin
        $display("%0t: no word moved for %0d cycles", $time, LIMIT_CYCLES);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offers one word, possibly after some idle cycles, and predicts it once taken.
  // A typed row replaces the predicted bar word with the one written in the table.
  // Called and returning just after a rising edge.
  task automatic push_item(input item_t w, input bit typed, input result_t want);
    bit taken;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do begin
      @(negedge clk);
      taken = item_ready;
      @(posedge clk);
    end while (!taken);
    advance_meter(w);
    if (typed) begin
      void'(bars_due.pop_back());
      bars_due.push_back(want);
    end
  endtask

  // Registers may only change once the block is idle: every owed bar word
  // has arrived and a dropped sample has had time to finish.
  task automatic settle();
    item_valid <= 1'b0;
    while (bars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    apply_reg(idx, val);
  endtask

  function automatic stim_row_t sample_row(input logic [2:0] ch, input logic [15:0] val,
                                           input bit typed = 1'b0,
                                           input logic [LEVEL_W-1:0] lvl = '0,
                                           input logic [LEVEL_W-1:0] pk = '0,
                                           input bit chg = 1'b0);
    stim_row_t row;
    row                  = '{default: '0};
    row.word.operation   = OP_SAMPLE;
    row.word.channel     = ch;
    row.word.value       = val;
    row.typed            = typed;
    row.want.out_channel = ch;
    row.want.level       = lvl;
    row.want.peak_mark   = pk;
    row.want.changed     = chg;
    row.want.last        = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t tick_row();
    stim_row_t row;
    row                = '{default: '0};
    row.word.operation = OP_TICK;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0]  val);
    stim_row_t row;
    row         = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  initial begin
    stim_row_t   steps[$];
    item_t       w;
    int          sent;
    int          mode;
    int          ceiling;
    logic [15:0] val;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Right after reset the meter is empty, so the first
    // samples can be read off directly: nothing, full scale, the SWR offset,
    // half scale on compression and exactly full scale on the S meter.
    steps.push_back(sample_row(CH_POWER,   16'h0000, 1'b1, '0, '0, 1'b0));
    steps.push_back(sample_row(CH_POWER,   16'hFFFF, 1'b1, FULL_FILL, FULL_FILL, 1'b1));
    steps.push_back(sample_row(CH_SWR,     16'h0100, 1'b1, '0, '0, 1'b0));
    steps.push_back(sample_row(CH_SWR,     16'hFFFF, 1'b1, FULL_FILL, FULL_FILL, 1'b1));
    steps.push_back(sample_row(CH_ALC,     16'hFFFF, 1'b1, FULL_FILL, FULL_FILL, 1'b1));
    steps.push_back(sample_row(CH_COMP,    16'h0C80, 1'b1, 17'h08000, 17'h08000, 1'b1));
    steps.push_back(sample_row(CH_CURRENT, 16'h0001));
    steps.push_back(sample_row(CH_SMETER,  16'h0F00, 1'b1, FULL_FILL, FULL_FILL, 1'b1));
    // Channels that do not exist are dropped without a word.
    steps.push_back(sample_row(CH_SPARE_LO, 16'h1234));
    steps.push_back(sample_row(CH_SPARE_HI, 16'hFFFF));
    // A lower reading only moves the target; display and peak stay put.
    steps.push_back(sample_row(CH_POWER, 16'h0000, 1'b1, FULL_FILL, FULL_FILL, 1'b0));
    steps.push_back(tick_row());
    steps.push_back(tick_row());
    // A step of full scale drops the display onto its target in one tick,
    // and the next tick only counts the hold down.
    steps.push_back(reg_row(REG_DECAY_STEP, 17'h10000));
    steps.push_back(tick_row());
    steps.push_back(tick_row());
    // An empty power full scale behaves as one watt.
    steps.push_back(reg_row(REG_POWER_FULL, 17'd0));
    steps.push_back(sample_row(CH_POWER, 16'h0080));
    steps.push_back(reg_row(REG_QRP_MODE, 17'd1));
    steps.push_back(reg_row(REG_QRP_FULL, 17'd255));
    steps.push_back(sample_row(CH_POWER, 16'hFFFF));
    steps.push_back(reg_row(REG_PEAK_HOLD_TICKS, 17'd0));
    steps.push_back(reg_row(REG_PEAK_DECAY_STEP, 17'h10000));
    steps.push_back(tick_row());
    steps.push_back(tick_row());

    foreach (steps[i]) begin
      if (steps[i].is_reg) begin
        settle();
        write_reg(steps[i].reg_idx, steps[i].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        push_item(steps[i].word, steps[i].typed, steps[i].want);
      end
    end

    // Random part. Each phase loads a fresh register set (all minimum, all
    // maximum, then random) and runs under one idling pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        write_reg(REG_QRP_MODE,        17'd0);
        write_reg(REG_POWER_FULL,      17'd1);
        write_reg(REG_QRP_FULL,        17'd1);
        write_reg(REG_DECAY_STEP,      17'd0);
        write_reg(REG_PEAK_DECAY_STEP, 17'd0);
        write_reg(REG_PEAK_HOLD_TICKS, 17'd0);
      end else if (ph == 1) begin
        write_reg(REG_QRP_MODE,        17'd1);
        write_reg(REG_POWER_FULL,      17'd255);
        write_reg(REG_QRP_FULL,        17'd255);
        write_reg(REG_DECAY_STEP,      17'h10000);
        write_reg(REG_PEAK_DECAY_STEP, 17'h10000);
        write_reg(REG_PEAK_HOLD_TICKS, 17'd255);
      end else begin
        write_reg(REG_QRP_MODE,        17'($urandom_range(0, 1)));
        write_reg(REG_POWER_FULL,      17'($urandom_range(0, 255)));
        write_reg(REG_QRP_FULL,        17'($urandom_range(1, 255)));
        // Mostly steps that take a few ticks to settle, now and then a big one.
        write_reg(REG_DECAY_STEP,      ($urandom_range(0, 3) == 0) ?
                                       17'($urandom_range(0, 65536)) :
                                       17'($urandom_range(0, 6000)));
        write_reg(REG_PEAK_DECAY_STEP, ($urandom_range(0, 3) == 0) ?
                                       17'($urandom_range(0, 65536)) :
                                       17'($urandom_range(0, 4000)));
        write_reg(REG_PEAK_HOLD_TICKS, ($urandom_range(0, 7) == 0) ?
                                       17'($urandom_range(0, 255)) :
                                       17'($urandom_range(0, 6)));
        // A write to an index with no register behind it must change nothing.
        if (ph == 3) write_reg(REG_SPARE, 17'($urandom));
      end
      cfg_valid <= 1'b0;

      mode = ph % 4;
      send_idle_pct  = (mode == 1) ? 82 : (mode == 3) ? 6 : 0;
      recv_stall_pct = (mode == 2) ? 82 : (mode == 3) ? 6 : 0;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        w = item_t'($urandom);
        if ($urandom_range(0, 99) < 25) begin
          // Channel and value are don't-care on a tick and stay random.
          w.operation = OP_TICK;
        end else begin
          w.operation = OP_SAMPLE;
          w.channel   = ($urandom_range(0, 99) < 5) ? 3'($urandom_range(CH_SPARE_LO, CH_SPARE_HI))
                                                     : 3'($urandom_range(0, CHANNELS - 1));
          ceiling = (int'(span_units(w.channel)) + 1) * 256;
          if (ceiling > 65535) ceiling = 65535;
          case ($urandom_range(0, 7))
            0:       val = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1, 2:    val = 16'($urandom);
            3:       val = 16'($urandom_range(0, 2)) + ((w.channel == CH_SWR) ? 16'd255 : 16'd0);
            default: val = 16'($urandom_range(0, ceiling));
          endcase
          w.value = val;
        end
        push_item(w, 1'b0, '0);
        if (w.operation == OP_TICK || int'(w.channel) < CHANNELS) begin
          sent = sent + 1;
          // Halfway through, hold the sender back until the meter has caught up.
          if (sent == ITEMS_PER_PHASE / 2) begin
            item_valid <= 1'b0;
            while (bars_due.size() != 0) @(posedge clk);
          end
        end
      end
    end

    item_valid <= 1'b0;
    while (bars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!fault_seen && bars_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/bmph_pkg.sv
design/bmph_sub.sv
design/bmph_cfg.sv
design/bmph_seq.sv
design/bar_meter_peak_hold.sv
tb/sv/testbench.sv
